// ----- rtl/fcd_pkg.sv -----
// Shared constants, types and codes of the frame change detector.
`default_nettype none

package fcd_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CFG_W      = 12;
   localparam int THR_W      = 14;
   localparam int CSR_DATA_W = 14;
   localparam int PIX_W      = 8;
   localparam int SZ_W       = ((COL_W > CFG_W) ? ((COL_W > ROW_W) ? COL_W : ROW_W)
                                : ((CFG_W > ROW_W) ? CFG_W : ROW_W)) + 1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
   localparam logic [THR_W-1:0] THR_RESET    = THR_W'(500);

   localparam int GRAY_SUM_W = 22;
   localparam int GRAY_SHIFT = 14;
   localparam logic [GRAY_SUM_W-1:0] COEF_RED   = GRAY_SUM_W'(4899);
   localparam logic [GRAY_SUM_W-1:0] COEF_GREEN = GRAY_SUM_W'(9617);
   localparam logic [GRAY_SUM_W-1:0] COEF_BLUE  = GRAY_SUM_W'(1868);
   localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = GRAY_SUM_W'(8192);

   localparam int SUM_W      = 12;
   localparam int DIV9_W     = 13;
   localparam int DIV9_PROD_W = SUM_W + DIV9_W;
   localparam int DIV9_SHIFT = 16;
   localparam logic [DIV9_W-1:0] DIV9_RECIP = DIV9_W'(7282);
   localparam logic [SUM_W-1:0]  ROUND_BIAS = SUM_W'(4);

   localparam int CMP_W = THR_W + PIX_W;
   localparam logic [CMP_W-1:0] PCT_SCALE  = CMP_W'(10000);
   localparam logic [CMP_W-1:0] FULL_SCALE = CMP_W'(255);

   localparam int RSP_DEPTH = 2;
   localparam int NUM_FILT  = 4;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH      = 2'd0,
      CSR_FRAME_HEIGHT     = 2'd1,
      CSR_CHANGE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic first;
      logic col_ge1;
      logic col_is1;
      logic row_ge1;
      logic row_is1;
      logic last_col;
      logic last_row;
      logic prev_present;
   } fcd_flags_type;

   typedef struct packed {
      logic [PIX_W-1:0] older;
      logic [PIX_W-1:0] newer;
   } fcd_line_type;

   typedef struct packed {
      logic             changed;
      logic [PIX_W-1:0] peak;
   } fcd_result_type;

endpackage

`default_nettype wire

// ----- rtl/fcd_gray.sv -----
// Registered RGB to gray conversion of the previous and current pixel.
`default_nettype none

module fcd_gray import fcd_pkg::*; (
   input  logic             clock,
   input  logic [PIX_W-1:0] prev_red,
   input  logic [PIX_W-1:0] prev_green,
   input  logic [PIX_W-1:0] prev_blue,
   input  logic [PIX_W-1:0] cur_red,
   input  logic [PIX_W-1:0] cur_green,
   input  logic [PIX_W-1:0] cur_blue,
   output logic [PIX_W-1:0] prev_gray,
   output logic [PIX_W-1:0] cur_gray
);

   logic [GRAY_SUM_W-1:0] prev_sum;
   logic [GRAY_SUM_W-1:0] cur_sum;
   logic [PIX_W-1:0]      prev_gray_ff;
   logic [PIX_W-1:0]      cur_gray_ff;

   always_comb begin
      prev_sum = GRAY_SUM_W'(prev_red) * COEF_RED + GRAY_SUM_W'(prev_green) * COEF_GREEN
               + GRAY_SUM_W'(prev_blue) * COEF_BLUE + GRAY_ROUND;
      cur_sum  = GRAY_SUM_W'(cur_red) * COEF_RED + GRAY_SUM_W'(cur_green) * COEF_GREEN
               + GRAY_SUM_W'(cur_blue) * COEF_BLUE + GRAY_ROUND;
   end

   always_ff @(posedge clock) begin
      prev_gray_ff <= prev_sum[GRAY_SHIFT +: PIX_W];
      cur_gray_ff  <= cur_sum[GRAY_SHIFT +: PIX_W];
   end

   assign prev_gray = prev_gray_ff;
   assign cur_gray  = cur_gray_ff;

endmodule

`default_nettype wire

// ----- rtl/fcd_line_buf.sv -----
// Two-line difference buffer with registered read and same-edge write bypass.
`default_nettype none

module fcd_line_buf import fcd_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  fcd_line_type     wr_data,
   output fcd_line_type     rd_data
);

   fcd_line_type mem [MAX_WIDTH];
   fcd_line_type rd_ff;
   fcd_line_type byp_data_ff;
   fcd_line_type out_ff;
   logic         byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
      out_ff <= byp_ff ? byp_data_ff : rd_ff;
   end

   assign rd_data = out_ff;

endmodule

`default_nettype wire

// ----- rtl/fcd_filter.sv -----
// Difference window, 3x3 box sums and rounded division by nine.
`default_nettype none

module fcd_filter import fcd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  fcd_flags_type                 in_flags,
   input  logic [PIX_W-1:0]              prev_gray,
   input  logic [PIX_W-1:0]              cur_gray,
   input  fcd_line_type                  line,
   output fcd_line_type                  wr_data,
   output logic                          out_valid,
   output fcd_flags_type                 out_flags,
   output logic [NUM_FILT-1:0][PIX_W-1:0] out_mean
);

   logic [PIX_W-1:0]                     diff;
   logic [2:0][2:0][PIX_W-1:0]           window_ff;
   logic [2:0][2:0][PIX_W-1:0]           window_in;
   logic                                 win_valid_ff;
   fcd_flags_type                        win_flags_ff;
   logic [2:0][PIX_W+1:0]                col_a;
   logic [2:0][PIX_W+1:0]                col_b;
   logic [1:0]                           lft;
   logic [NUM_FILT-1:0]                  filt_en;
   logic [NUM_FILT-1:0][SUM_W-1:0]       sum_in;
   logic [NUM_FILT-1:0][SUM_W-1:0]       sum_ff;
   logic                                 sum_valid_ff;
   fcd_flags_type                        sum_flags_ff;
   logic [NUM_FILT-1:0][DIV9_PROD_W-1:0] prod;
   logic [NUM_FILT-1:0][PIX_W-1:0]       mean_ff;
   logic                                 mean_valid_ff;
   fcd_flags_type                        mean_flags_ff;

   // shift in the new column: older line, newer line, this difference
   always_comb begin
      diff = (prev_gray > cur_gray) ? (prev_gray - cur_gray) : (cur_gray - prev_gray);
      window_in = window_ff;
      for (int i = 0; i < 3; i++) begin
         window_in[i][0] = window_ff[i][1];
         window_in[i][1] = window_ff[i][2];
      end
      window_in[0][2] = line.older;
      window_in[1][2] = line.newer;
      window_in[2][2] = diff;
      wr_data.older   = line.newer;
      wr_data.newer   = diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         win_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= in_valid;
         if (in_valid) begin
            window_ff <= window_in;
         end
      end
      win_flags_ff <= in_flags;
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         col_a[j] = (win_flags_ff.row_is1 ? (PIX_W+2)'(window_ff[2][j])
                                          : (PIX_W+2)'(window_ff[0][j]))
                  + (PIX_W+2)'(window_ff[1][j]) + (PIX_W+2)'(window_ff[2][j]);
         col_b[j] = ((PIX_W+2)'(window_ff[1][j]) << 1) + (PIX_W+2)'(window_ff[2][j]);
      end
      lft = win_flags_ff.col_is1 ? 2'd2 : 2'd0;
      filt_en[0] = win_flags_ff.col_ge1 && win_flags_ff.row_ge1;
      filt_en[1] = filt_en[0] && win_flags_ff.last_col;
      filt_en[2] = win_flags_ff.col_ge1 && win_flags_ff.last_row;
      filt_en[3] = filt_en[2] && win_flags_ff.last_col;
      sum_in[0] = SUM_W'(col_a[lft]) + SUM_W'(col_a[1]) + SUM_W'(col_a[2]) + ROUND_BIAS;
      sum_in[1] = (SUM_W'(col_a[1]) << 1) + SUM_W'(col_a[2]) + ROUND_BIAS;
      sum_in[2] = SUM_W'(col_b[lft]) + SUM_W'(col_b[1]) + SUM_W'(col_b[2]) + ROUND_BIAS;
      sum_in[3] = (SUM_W'(col_b[1]) << 1) + SUM_W'(col_b[2]) + ROUND_BIAS;
      for (int k = 0; k < NUM_FILT; k++) begin
         if (!filt_en[k]) begin
            sum_in[k] = '0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_FILT; k++) begin
         prod[k] = DIV9_PROD_W'(sum_ff[k]) * DIV9_PROD_W'(DIV9_RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         mean_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff  <= win_valid_ff;
         mean_valid_ff <= sum_valid_ff;
      end
      sum_ff        <= sum_in;
      sum_flags_ff  <= win_flags_ff;
      mean_flags_ff <= sum_flags_ff;
      for (int k = 0; k < NUM_FILT; k++) begin
         mean_ff[k] <= prod[k][DIV9_SHIFT +: PIX_W];
      end
   end

   assign out_valid = mean_valid_ff;
   assign out_flags = mean_flags_ff;
   assign out_mean  = mean_ff;

endmodule

`default_nettype wire

// ----- rtl/fcd_peak.sv -----
// Frame peak tracking and threshold decision at the last pixel.
`default_nettype none

module fcd_peak import fcd_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  fcd_flags_type                  in_flags,
   input  logic [NUM_FILT-1:0][PIX_W-1:0] in_mean,
   input  logic [THR_W-1:0]               threshold,
   output logic                           res_valid,
   output fcd_result_type                 res_data
);

   logic [PIX_W-1:0] peak_ff;
   logic [PIX_W-1:0] peak_in;
   logic [PIX_W-1:0] peak_max;
   logic             has_prev_ff;
   logic             has_prev_in;
   logic             fin_valid_ff;
   logic             fin_has_ff;
   logic [PIX_W-1:0] fin_peak_ff;
   logic             res_valid_ff;
   fcd_result_type   res_ff;
   logic [CMP_W-1:0] lhs;
   logic [CMP_W-1:0] rhs;

   always_comb begin
      peak_max = peak_ff;
      for (int k = 0; k < NUM_FILT; k++) begin
         if (in_mean[k] > peak_max) begin
            peak_max = in_mean[k];
         end
      end
      has_prev_in = in_flags.first ? in_flags.prev_present : has_prev_ff;
      peak_in = (in_flags.last_col && in_flags.last_row) ? '0 : peak_max;
   end

   always_comb begin
      lhs = CMP_W'(fin_peak_ff) * PCT_SCALE;
      rhs = CMP_W'(threshold) * FULL_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         has_prev_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= in_valid && in_flags.last_col && in_flags.last_row;
         res_valid_ff <= fin_valid_ff;
         if (in_valid) begin
            peak_ff     <= peak_in;
            has_prev_ff <= has_prev_in;
         end
      end
      fin_has_ff     <= has_prev_in;
      fin_peak_ff    <= has_prev_in ? peak_max : '0;
      res_ff.changed <= fin_has_ff && (lhs >= rhs);
      res_ff.peak    <= fin_peak_ff;
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;

endmodule

`default_nettype wire

// ----- rtl/frame_change_detector_unit.sv -----
// Frame change detector top level: counters, pipeline, result queue, registers.
//
// Usage: req_ carries one co-located pixel pair per word in raster order:
// previous and current RGB in req_tdata, the previous-frame-present flag in
// req_tuser (sampled on the first pixel of a frame). One word per clock is
// taken when nothing stalls. After the last pixel of a frame one result word
// appears on rsp_: the changed flag and the frame's peak filtered difference.
// The last pixel's result passes the input register, gray conversion,
// window, box sums, divide by nine, peak, compare and result queue. The
// throughput is one pixel per cycle while req_tready is high, set by the
// single line buffer port pair (read on accept, write from stage two,
// bypassed on a collision). A two-word result queue separates the sides; a
// stalled receiver only holds req_tready low on the last pixel of a
// frame while two results are owed. csr_ writes frame_width, frame_height
// and change_threshold; always ready; write only while the block is idle.
// Reset (synchronous, active high) restores 640 x 480 and threshold 500,
// clears counters, window, peak and queue; line buffer content is not cleared.
`default_nettype none

module frame_change_detector_unit import fcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: prev_red, prev_green, prev_blue, cur_red, cur_green, cur_blue
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [6*PIX_W-1:0]    req_tdata,
   // req_tuser: prev_present
   input  logic                  req_tuser,
   // rsp_tdata: changed, peak_difference, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [CFG_W-1:0]  width_ff;
   logic [CFG_W-1:0]  height_ff;
   logic [THR_W-1:0]  thresh_ff;
   logic [SZ_W-1:0]   width_ext;
   logic [SZ_W-1:0]   height_ext;
   logic [SZ_W-1:0]   width_eff;
   logic [SZ_W-1:0]   height_eff;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   fcd_flags_type     front_flags;
   logic              front_last;
   logic              accept;
   logic              s1_valid_ff;
   fcd_flags_type     s1_flags_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [6*PIX_W-1:0] s1_pix_ff;
   logic              s2_valid_ff;
   fcd_flags_type     s2_flags_ff;
   logic [COL_W-1:0]  s2_col_ff;
   logic [PIX_W-1:0]  prev_gray;
   logic [PIX_W-1:0]  cur_gray;
   fcd_line_type      line_rd;
   fcd_line_type      line_wr;
   logic              filt_valid;
   fcd_flags_type     filt_flags;
   logic [NUM_FILT-1:0][PIX_W-1:0] filt_mean;
   logic              res_valid;
   fcd_result_type    res_data;
   fcd_result_type    queue_ff [RSP_DEPTH];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        q_cnt_ff;
   logic [1:0]        q_cnt_in;
   logic [1:0]        owed_ff;
   logic [1:0]        owed_in;
   logic              pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:      width_ff  <= csr_data[CFG_W-1:0];
            CSR_FRAME_HEIGHT:     height_ff <= csr_data[CFG_W-1:0];
            CSR_CHANGE_THRESHOLD: thresh_ff <= csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp geometry and derive the position flags of the next word
   always_comb begin
      width_ext  = SZ_W'(width_ff);
      height_ext = SZ_W'(height_ff);
      priority if (width_ext < SZ_W'(2)) begin
         width_eff = SZ_W'(2);
      end else if (width_ext > SZ_W'(MAX_WIDTH)) begin
         width_eff = SZ_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      priority if (height_ext < SZ_W'(2)) begin
         height_eff = SZ_W'(2);
      end else if (height_ext > SZ_W'(MAX_HEIGHT)) begin
         height_eff = SZ_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ext;
      end
      front_flags.first        = (col_ff == '0) && (row_ff == '0);
      front_flags.col_ge1      = (col_ff != '0);
      front_flags.col_is1      = (col_ff == COL_W'(1));
      front_flags.row_ge1      = (row_ff != '0);
      front_flags.row_is1      = (row_ff == ROW_W'(1));
      front_flags.last_col     = SZ_W'(col_ff) >= (width_eff - SZ_W'(1));
      front_flags.last_row     = SZ_W'(row_ff) >= (height_eff - SZ_W'(1));
      front_flags.prev_present = req_tuser;
      front_last = front_flags.last_col && front_flags.last_row;
   end

   assign req_tready = !(front_last && (owed_ff == 2'(RSP_DEPTH)));
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (front_flags.last_col) begin
            col_in = '0;
            row_in = front_flags.last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // pipeline control, stages one and two
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_flags_ff <= front_flags;
      s1_col_ff   <= col_ff;
      s1_pix_ff   <= req_tdata;
      s2_flags_ff <= s1_flags_ff;
      s2_col_ff   <= s1_col_ff;
   end

   fcd_gray u_gray (
      .clock      (clock),
      .prev_red   (s1_pix_ff[0*PIX_W +: PIX_W]),
      .prev_green (s1_pix_ff[1*PIX_W +: PIX_W]),
      .prev_blue  (s1_pix_ff[2*PIX_W +: PIX_W]),
      .cur_red    (s1_pix_ff[3*PIX_W +: PIX_W]),
      .cur_green  (s1_pix_ff[4*PIX_W +: PIX_W]),
      .cur_blue   (s1_pix_ff[5*PIX_W +: PIX_W]),
      .prev_gray  (prev_gray),
      .cur_gray   (cur_gray)
   );

   fcd_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_col_ff),
      .wr_data (line_wr),
      .rd_data (line_rd)
   );

   fcd_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_flags  (s2_flags_ff),
      .prev_gray (prev_gray),
      .cur_gray  (cur_gray),
      .line      (line_rd),
      .wr_data   (line_wr),
      .out_valid (filt_valid),
      .out_flags (filt_flags),
      .out_mean  (filt_mean)
   );

   fcd_peak u_peak (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (filt_valid),
      .in_flags  (filt_flags),
      .in_mean   (filt_mean),
      .threshold (thresh_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // result queue and owed-result count
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_tdata  = {7'b0, queue_ff[rd_ptr_ff].peak, queue_ff[rd_ptr_ff].changed};

   always_comb begin
      q_cnt_in = q_cnt_ff + 2'(res_valid) - 2'(pop);
      owed_in  = owed_ff + 2'(accept && front_last) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= 2'd0;
         owed_ff   <= 2'd0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         owed_ff  <= owed_in;
         if (res_valid) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (res_valid) begin
         queue_ff[wr_ptr_ff] <= res_data;
      end
   end

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (q_cnt_ff != 2'(RSP_DEPTH)) || pop)
      else $error("result queue overflow");

   a_owed_covers_queue: assert property (@(posedge clock) disable iff (reset)
      owed_ff >= q_cnt_ff)
      else $error("queued results exceed owed count");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && front_last |=> (col_ff == '0) && (row_ff == '0))
      else $error("position counters did not wrap after last pixel");

   a_last_gate: assert property (@(posedge clock) disable iff (reset)
      accept && front_last |-> owed_ff < 2'(RSP_DEPTH))
      else $error("last pixel accepted with no room for its result");
`endif

endmodule

`default_nettype wire
